// ===== src/tft_pkg.sv =====
package tft_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int TOKEN_BYTES = 64;

	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
	localparam int POS_W = $clog2(TOKEN_BYTES);
	localparam int LEN_W = $clog2(TOKEN_BYTES + 1);
	localparam int CNT_W = 32;
	localparam int TEXT_W = TOKEN_BYTES * 8;
	localparam int ROW_W = TEXT_W + LEN_W + CNT_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_PERIOD = 8'h2e;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic MODE_TEXT = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic load;
		logic active;
	} cell_ctrl_t;

	typedef struct packed {
		logic closed;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0] count;
		logic was_new;
		logic dropped;
		logic truncated;
		logic [7:0] data;
		logic [LEN_W-1:0] length;
	} res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ===== src/tft_ram.sv =====
module tft_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(D)-1:0] waddr,
	input logic [W-1:0] wdata,
	input logic re,
	input logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/tft_cell.sv =====
module tft_cell (
	input logic clk,
	input tft_pkg::cell_ctrl_t ctrl,
	input logic [7:0] data_in,
	input logic [7:0] row_byte,
	output logic [7:0] held,
	output logic eq
);
	import tft_pkg::*;

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= data_in;
		end
	end

	assign held = byte_q;
	// positions past the pending length always agree
	assign eq = !ctrl.active || (byte_q == row_byte);
endmodule

// ===== src/token_frequency_table.sv =====
// token frequency table
// in channel (in_valid/in_ready): mode, text_byte, entry_index, char_position.
// mode 0 feeds one text byte; bytes are split into tokens on space, comma and,
// when period_splits is set, period. a newline ends its token and is kept.
// mode 1 reads one table slot: count, length and the byte at char_position.
// out channel (out_valid/out_ready): exactly one result item per input item.
// cfg channel (cfg_valid/cfg_ready/cfg_data) writes period_splits; always ready.
// a byte that closes no token goes from decode straight to the output state;
// a read of an occupied slot first passes a ram wait state. a closing byte
// scans the occupied slots one at a time, a ram read state and then a compare
// state per slot through the single table ram read port, until a match; on an
// empty table it inserts without a scan. one item is in flight at a time;
// in_ready is high only while idle, rising with out_valid.
// a stalled receiver holds the result in the output register; the block
// finishes its work and then waits before taking the next item.
// reset clears the table fill count, totals, pending token and period_splits.
module token_frequency_table (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic mode,
	input logic [7:0] text_byte,
	input logic [tft_pkg::SLOT_W-1:0] entry_index,
	input logic [tft_pkg::POS_W-1:0] char_position,
	output logic out_valid,
	input logic out_ready,
	output logic token_closed,
	output logic [tft_pkg::SLOT_W-1:0] slot,
	output logic [tft_pkg::CNT_W-1:0] slot_count,
	output logic was_new,
	output logic dropped,
	output logic truncated,
	output logic [tft_pkg::CNT_W-1:0] total_tokens,
	output logic [tft_pkg::OCC_W-1:0] distinct_entries,
	output logic [7:0] entry_byte,
	output logic [tft_pkg::LEN_W-1:0] entry_length,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data
);
	import tft_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SRD = 3'd2;
	localparam logic [2:0] S_SCMP = 3'd3;
	localparam logic [2:0] S_RDWAIT = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0] state_q;
	logic period_splits_q;
	logic mode_q;
	logic [7:0] byte_q;
	logic [SLOT_W-1:0] idx_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] tok_len_q;
	logic tok_ovf_q;
	logic [OCC_W-1:0] occ_q;
	logic [CNT_W-1:0] total_q;
	logic [SLOT_W-1:0] scan_q;
	res_t res_q;
	res_t out_res_q;
	logic out_valid_q;
	logic [CNT_W-1:0] out_total_q;
	logic [OCC_W-1:0] out_distinct_q;

	logic ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	logic [ROW_W-1:0] ram_rdata;

	logic [TEXT_W-1:0] row_text;
	logic [LEN_W-1:0] row_len;
	logic [CNT_W-1:0] row_cnt;
	logic [TEXT_W-1:0] tok_text;
	logic [TOKEN_BYTES-1:0] cell_eq;
	cell_ctrl_t cell_ctrl [TOKEN_BYTES];

	logic push;
	logic [7:0] low_byte;
	logic is_delim;
	logic row_match;
	logic [OCC_W-1:0] scan_next;
	logic out_free;

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;

	assign row_text = ram_rdata[TEXT_W-1:0];
	assign row_len = ram_rdata[TEXT_W +: LEN_W];
	assign row_cnt = ram_rdata[TEXT_W+LEN_W +: CNT_W];

	assign low_byte = (byte_q >= CH_UPPER_A && byte_q <= CH_UPPER_Z) ?
		byte_q + CASE_OFFSET : byte_q;
	assign is_delim = (byte_q == CH_SPACE) || (byte_q == CH_COMMA) ||
		(byte_q == CH_PERIOD && period_splits_q);
	assign push = (state_q == S_DECODE) && (mode_q == MODE_TEXT) &&
		(byte_q != CH_NUL) && !is_delim && (tok_len_q < LEN_W'(TOKEN_BYTES));

	for (genvar i = 0; i < TOKEN_BYTES; i++) begin : g_cell
		assign cell_ctrl[i].load = push && (tok_len_q[POS_W-1:0] == POS_W'(i));
		assign cell_ctrl[i].active = (LEN_W'(i) < tok_len_q);
		tft_cell u_cell (
			.clk(clk),
			.ctrl(cell_ctrl[i]),
			.data_in(low_byte),
			.row_byte(row_text[i*8 +: 8]),
			.held(tok_text[i*8 +: 8]),
			.eq(cell_eq[i])
		);
	end

	// an empty table has no row loaded, so nothing can match
	assign row_match = (occ_q != '0) && (row_len == tok_len_q) && (&cell_eq);
	assign scan_next = OCC_W'(scan_q) + OCC_W'(1);

	tft_ram #(.W(ROW_W), .D(TABLE_DEPTH)) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_re = 1'b0;
		ram_raddr = scan_q;
		ram_we = 1'b0;
		ram_waddr = scan_q;
		ram_wdata = {row_cnt, row_len, row_text};
		if (state_q == S_DECODE && mode_q == MODE_READ) begin
			ram_re = 1'b1;
			ram_raddr = idx_q;
		end
		if (state_q == S_SRD) begin
			ram_re = 1'b1;
		end
		if (state_q == S_SCMP) begin
			if (row_match) begin
				ram_we = 1'b1;
				ram_wdata = {sat_inc(row_cnt), row_len, row_text};
			end else if (scan_next >= occ_q && occ_q < OCC_W'(TABLE_DEPTH)) begin
				ram_we = 1'b1;
				ram_waddr = occ_q[SLOT_W-1:0];
				ram_wdata = {CNT_W'(1), tok_len_q, tok_text};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			period_splits_q <= 1'b0;
			tok_len_q <= '0;
			tok_ovf_q <= 1'b0;
			occ_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				period_splits_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (mode_q == MODE_READ) begin
						state_q <= (OCC_W'(idx_q) < occ_q) ? S_RDWAIT : S_OUT;
					end else if (byte_q == CH_NUL) begin
						state_q <= S_OUT;
					end else if (is_delim) begin
						// empty table: no scan, go straight to insert
						state_q <= (tok_len_q == '0) ? S_OUT :
							(occ_q == '0) ? S_SCMP : S_SRD;
					end else begin
						if (tok_len_q < LEN_W'(TOKEN_BYTES)) begin
							tok_len_q <= tok_len_q + LEN_W'(1);
						end else begin
							tok_ovf_q <= 1'b1;
						end
						state_q <= (byte_q != CH_NEWLINE) ? S_OUT :
							(occ_q == '0) ? S_SCMP : S_SRD;
					end
				end
				S_SRD: begin
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (!row_match && scan_next < occ_q) begin
						state_q <= S_SRD;
					end else begin
						if (!row_match && occ_q < OCC_W'(TABLE_DEPTH)) begin
							occ_q <= occ_q + OCC_W'(1);
						end
						total_q <= sat_inc(total_q);
						tok_len_q <= '0;
						tok_ovf_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_RDWAIT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item capture, scan pointer and result build
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mode_q <= mode;
			byte_q <= text_byte;
			idx_q <= entry_index;
			pos_q <= char_position;
		end
		if (state_q == S_DECODE) begin
			scan_q <= '0;
			res_q <= '{slot: (mode_q == MODE_READ) ? idx_q : '0, default: '0};
		end
		if (state_q == S_SCMP) begin
			res_q.closed <= 1'b1;
			res_q.truncated <= tok_ovf_q;
			if (occ_q != '0 && row_match) begin
				res_q.slot <= scan_q;
				res_q.count <= sat_inc(row_cnt);
				res_q.length <= row_len;
			end else if (occ_q != '0 && scan_next < occ_q) begin
				scan_q <= scan_q + SLOT_W'(1);
			end else if (occ_q < OCC_W'(TABLE_DEPTH)) begin
				res_q.slot <= occ_q[SLOT_W-1:0];
				res_q.count <= CNT_W'(1);
				res_q.was_new <= 1'b1;
				res_q.length <= tok_len_q;
			end else begin
				res_q.dropped <= 1'b1;
			end
		end
		if (state_q == S_RDWAIT) begin
			res_q.count <= row_cnt;
			res_q.length <= row_len;
			res_q.data <= (LEN_W'(pos_q) < row_len) ? row_text[pos_q*8 +: 8] : 8'h00;
		end
		if (state_q == S_OUT && out_free) begin
			out_res_q <= res_q;
			out_total_q <= total_q;
			out_distinct_q <= occ_q;
		end
	end

	assign out_valid = out_valid_q;
	assign token_closed = out_res_q.closed;
	assign slot = out_res_q.slot;
	assign slot_count = out_res_q.count;
	assign was_new = out_res_q.was_new;
	assign dropped = out_res_q.dropped;
	assign truncated = out_res_q.truncated;
	assign total_tokens = out_total_q;
	assign distinct_entries = out_distinct_q;
	assign entry_byte = out_res_q.data;
	assign entry_length = out_res_q.length;
endmodule

// ===== sim/token_frequency_table_tb.sv =====
module token_frequency_table_tb;
	import tft_pkg::*;

	typedef struct {
		logic closed;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0] count;
		logic was_new;
		logic dropped;
		logic truncated;
		logic [CNT_W-1:0] total;
		logic [OCC_W-1:0] distinct;
		logic [7:0] data;
		logic [LEN_W-1:0] length;
	} tally_t;

	class tally_scoreboard;
		logic [7:0] words[TABLE_DEPTH][TOKEN_BYTES];
		int word_len[TABLE_DEPTH];
		logic [CNT_W-1:0] word_count[TABLE_DEPTH];
		logic [7:0] pending[TOKEN_BYTES];
		int pending_len;
		bit pending_cut;
		int occupied;
		logic [CNT_W-1:0] total;
		bit period_splits;
		tally_t expected[$];
		int errors;

		function void bump(ref logic [CNT_W-1:0] v);
			if (v != COUNT_MAX)
				v = v + CNT_W'(1);
		endfunction

		function void close_word(ref tally_t r);
			int s;
			int hit;
			hit = -1;
			for (s = 0; s < occupied && hit < 0; s++) begin
				if (word_len[s] == pending_len) begin
					hit = s;
					for (int k = 0; k < pending_len; k++)
						if (words[s][k] != pending[k])
							hit = -1;
				end
			end
			r.closed = 1;
			r.truncated = pending_cut;
			if (hit >= 0) begin
				bump(word_count[hit]);
				r.slot = SLOT_W'(hit);
				r.count = word_count[hit];
				r.length = LEN_W'(word_len[hit]);
			end else if (occupied < TABLE_DEPTH) begin
				for (int k = 0; k < pending_len; k++)
					words[occupied][k] = pending[k];
				word_len[occupied] = pending_len;
				word_count[occupied] = CNT_W'(1);
				r.slot = SLOT_W'(occupied);
				r.count = CNT_W'(1);
				r.was_new = 1;
				r.length = LEN_W'(pending_len);
				occupied++;
			end else begin
				r.dropped = 1;
			end
			bump(total);
			pending_len = 0;
			pending_cut = 0;
		endfunction

		function void append(logic [7:0] b);
			if (b >= CH_UPPER_A && b <= CH_UPPER_Z)
				b = b + CASE_OFFSET;
			if (pending_len < TOKEN_BYTES) begin
				pending[pending_len] = b;
				pending_len++;
			end else begin
				pending_cut = 1;
			end
		endfunction

		function void note_item(logic m, logic [7:0] b, logic [SLOT_W-1:0] ix,
				logic [POS_W-1:0] p);
			tally_t r;
			r = '{default: 0};
			if (m == MODE_READ) begin
				r.slot = ix;
				if (ix < occupied) begin
					r.count = word_count[ix];
					r.length = LEN_W'(word_len[ix]);
					if (p < word_len[ix])
						r.data = words[ix][p];
				end
			end else if (b != CH_NUL) begin
				if (b == CH_SPACE || b == CH_COMMA || (b == CH_PERIOD && period_splits)) begin
					if (pending_len > 0)
						close_word(r);
				end else if (b == CH_NEWLINE) begin
					append(b);
					close_word(r);
				end else begin
					append(b);
				end
			end
			r.total = total;
			r.distinct = OCC_W'(occupied);
			expected.push_back(r);
		endfunction

		function void field(string name, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				$error("%s: expected %0h, got %0h", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(tally_t a);
			tally_t e;
			if (expected.size() == 0) begin
				$error("result with nothing outstanding");
				errors++;
				return;
			end
			e = expected.pop_front();
			field("token_closed", e.closed, a.closed);
			field("slot", e.slot, a.slot);
			field("slot_count", e.count, a.count);
			field("was_new", e.was_new, a.was_new);
			field("dropped", e.dropped, a.dropped);
			field("truncated", e.truncated, a.truncated);
			field("total_tokens", e.total, a.total);
			field("distinct_entries", e.distinct, a.distinct);
			field("entry_byte", e.data, a.data);
			field("entry_length", e.length, a.length);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	logic mode;
	logic [7:0] text_byte;
	logic [SLOT_W-1:0] entry_index;
	logic [POS_W-1:0] char_position;
	logic out_valid, out_ready;
	logic token_closed;
	logic [SLOT_W-1:0] slot;
	logic [CNT_W-1:0] slot_count;
	logic was_new, dropped, truncated;
	logic [CNT_W-1:0] total_tokens;
	logic [OCC_W-1:0] distinct_entries;
	logic [7:0] entry_byte;
	logic [LEN_W-1:0] entry_length;
	logic cfg_valid, cfg_ready, cfg_data;

	tally_scoreboard sb;
	int burst_left;
	int hold_request;
	int hold_left;
	int sent_items;

	token_frequency_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.text_byte(text_byte),
		.entry_index(entry_index),
		.char_position(char_position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_closed(token_closed),
		.slot(slot),
		.slot_count(slot_count),
		.was_new(was_new),
		.dropped(dropped),
		.truncated(truncated),
		.total_tokens(total_tokens),
		.distinct_entries(distinct_entries),
		.entry_byte(entry_byte),
		.entry_length(entry_length),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		tally_t a;
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(mode, text_byte, entry_index, char_position);
			if (out_valid && out_ready) begin
				a.closed = token_closed;
				a.slot = slot;
				a.count = slot_count;
				a.was_new = was_new;
				a.dropped = dropped;
				a.truncated = truncated;
				a.total = total_tokens;
				a.distinct = distinct_entries;
				a.data = entry_byte;
				a.length = entry_length;
				sb.check_result(a);
			end
		end
	end

	// receiver: random stalls, calm stretches, and long hold-offs on request
	initial begin
		int calm;
		calm = 0;
		hold_left = 0;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready = 0;
				hold_left--;
			end else if (calm > 0) begin
				out_ready = 1;
				calm--;
			end else if ($urandom_range(0, 15) == 0) begin
				calm = $urandom_range(10, 80);
				out_ready = 1;
			end else begin
				out_ready = $urandom_range(0, 3) != 0;
			end
		end
	end

	task automatic send(input logic m, input int unsigned b, input int unsigned ix,
			input int unsigned p);
		if (burst_left == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 60);
		end
		in_valid = 1;
		mode = m;
		text_byte = b[7:0];
		entry_index = ix[SLOT_W-1:0];
		char_position = p[POS_W-1:0];
		while (!in_ready)
			@(negedge clk);
		@(negedge clk);
		burst_left--;
		sent_items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send(MODE_TEXT, s[i], $urandom, $urandom);
	endtask

	task automatic read_entry(input int ix, input int p);
		send(MODE_READ, $urandom, ix, p);
	endtask

	task automatic drain();
		in_valid = 0;
		while (sb.expected.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_period_splits(input bit v);
		drain();
		cfg_valid = 1;
		cfg_data = v;
		while (!cfg_ready)
			@(negedge clk);
		@(negedge clk);
		cfg_valid = 0;
		sb.period_splits = v;
	endtask

	// random token, mostly from a small vocabulary with random case
	task automatic random_word();
		string vocab[8];
		string w;
		byte c;
		vocab = '{"the", "a", "of", "token", "e.g", "and", "Word", "zz"};
		case ($urandom_range(0, 19))
			0: begin
				repeat ($urandom_range(60, 72))
					send(MODE_TEXT, 8'h61 + $urandom_range(0, 2), $urandom, $urandom);
			end
			1, 2: begin
				repeat ($urandom_range(1, 4)) begin
					c = byte'($urandom);
					send(MODE_TEXT, c, $urandom, $urandom);
				end
			end
			default: begin
				w = vocab[$urandom_range(0, 7)];
				for (int i = 0; i < w.len(); i++) begin
					c = w[i];
					if (c >= "a" && c <= "z" && $urandom_range(0, 3) == 0)
						c = c - CASE_OFFSET;
					send(MODE_TEXT, c, $urandom, $urandom);
				end
			end
		endcase
		case ($urandom_range(0, 9))
			0: send(MODE_TEXT, CH_NEWLINE, $urandom, $urandom);
			1: send(MODE_TEXT, CH_COMMA, $urandom, $urandom);
			2: send(MODE_TEXT, CH_PERIOD, $urandom, $urandom);
			3: send_text(", ");
			4: send(MODE_TEXT, CH_NUL, $urandom, $urandom);
			default: send(MODE_TEXT, CH_SPACE, $urandom, $urandom);
		endcase
	endtask

	task automatic random_phase(input int items);
		int start;
		start = sent_items;
		while (sent_items - start < items) begin
			if ($urandom_range(0, 4) == 0) begin
				if (sb.occupied > 0 && $urandom_range(0, 3) != 0)
					read_entry($urandom_range(0, sb.occupied - 1), $urandom_range(0, 8));
				else
					read_entry($urandom, $urandom);
			end else begin
				random_word();
			end
		end
	endtask

	initial begin
		sb = new();
		sb.errors = 0;
		sb.pending_len = 0;
		sb.pending_cut = 0;
		sb.occupied = 0;
		sb.total = 0;
		sb.period_splits = 0;
		burst_left = 0;
		hold_request = 0;
		sent_items = 0;
		arst_n = 0;
		in_valid = 0;
		mode = MODE_TEXT;
		text_byte = 0;
		entry_index = 0;
		char_position = 0;
		cfg_valid = 0;
		cfg_data = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty reads, nul, case folding, repeated delimiters, newline, period
		write_period_splits(0);
		read_entry(0, 0);
		read_entry(TABLE_DEPTH - 1, TOKEN_BYTES - 1);
		send_text("AZ, ,az\n");
		send(MODE_TEXT, CH_NUL, 8'hff, 8'hff);
		send(MODE_TEXT, 8'hff, 0, 0);
		send_text("a.b ");
		read_entry(0, 0);
		read_entry(1, 2);
		read_entry(2, TOKEN_BYTES - 1);
		write_period_splits(1);
		send_text("a.b.");
		read_entry(3, 1);

		random_phase(200);
		// long receiver hold-off while the sender keeps offering items
		hold_request = 300;
		random_phase(40);
		drain();
		write_period_splits(0);
		random_phase(150);
		write_period_splits(1);
		random_phase(110);
		write_period_splits(0);

		// closing tokens and reads after the random phases
		send_text("x99999 yy, x0\nqq ");
		read_entry(TABLE_DEPTH - 1, 1);
		read_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);

		drain();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
